// File: design/text_stream_line_ending_checker_unit_assert.svh
// Assertion macros used by the checker file of this block.
// Every macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef TEXT_STREAM_LINE_ENDING_CHECKER_UNIT_ASSERT_SVH
`define TEXT_STREAM_LINE_ENDING_CHECKER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSLE_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("line ending checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define TSLE_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("line ending checker: next-cycle property failed");

`endif

// File: design/tsle_pkg.sv
package tsle_pkg;

   // Default width of the running byte offset.
   localparam int OFFSET_BITS_DEFAULT = 32;

   // Widths of the ports.
   localparam int OFFSET_OUT_BITS = 32;
   localparam int CSR_INDEX_BITS  = 8;
   localparam int CSR_DATA_BITS   = 8;

   // Depth of the queue between the front and the back (a power of two).
   localparam int Q_DEPTH    = 2;
   localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

   // Special byte values.
   localparam logic [7:0] BYTE_CR  = 8'h0D;
   localparam logic [7:0] BYTE_LF  = 8'h0A;
   localparam logic [7:0] BYTE_NUL = 8'h00;
   localparam logic [7:0] PRINT_LO = 8'h20;
   localparam logic [7:0] PRINT_HI = 8'h7E;

   // Line ending styles. Codes above LFCR are legal to write but match nothing.
   localparam logic [2:0] STYLE_LEARN = 3'd0;
   localparam logic [2:0] STYLE_CR    = 3'd1;
   localparam logic [2:0] STYLE_LF    = 3'd2;
   localparam logic [2:0] STYLE_CRLF  = 3'd3;
   localparam logic [2:0] STYLE_LFCR  = 3'd4;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHECK_ENDINGS      = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EXPECTED_STYLE     = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REJECT_ZERO        = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REJECT_UNPRINTABLE = 8'd3;

   // Verdict codes.
   typedef enum logic [2:0] {
      VERDICT_OK      = 3'd0,
      VERDICT_ENDING  = 3'd1,
      VERDICT_ZERO    = 3'd2,
      VERDICT_UNPRINT = 3'd3,
      VERDICT_FAILED  = 3'd4
   } verdict_type;

   // Line break waiting for the following byte.
   typedef enum logic [2:0] {
      WAIT_NONE = 3'b001,
      WAIT_CR   = 3'b010,
      WAIT_LF   = 3'b100
   } pend_type;

   // One classified byte as it travels from the front to the back.
   typedef struct packed {
      logic                       is_cr;
      logic                       is_lf;
      logic                       is_zero;
      logic                       is_unprint;
      logic                       last;
      logic [OFFSET_OUT_BITS-1:0] offset;
   } item_type;

endpackage

// File: design/tsle_front.sv
module tsle_front #(
   parameter int OFFSET_BITS = tsle_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               req_end_of_file,
   input  logic               q_ready,
   output logic               q_push,
   output tsle_pkg::item_type q_item
);

   localparam int WideBits = (OFFSET_BITS > tsle_pkg::OFFSET_OUT_BITS) ?
                             OFFSET_BITS : tsle_pkg::OFFSET_OUT_BITS;

   logic [OFFSET_BITS-1:0] offset_ff;
   logic [OFFSET_BITS-1:0] offset_in;
   logic [WideBits-1:0]    offset_wide;

   // A beat is taken whenever the queue has room.
   assign req_ready = q_ready;
   assign q_push    = req_valid && q_ready;

   // Classify the byte and tag it with its offset in the file.
   assign offset_wide       = WideBits'(offset_ff);
   assign q_item.is_cr      = (req_data_byte == tsle_pkg::BYTE_CR);
   assign q_item.is_lf      = (req_data_byte == tsle_pkg::BYTE_LF);
   assign q_item.is_zero    = (req_data_byte == tsle_pkg::BYTE_NUL);
   assign q_item.is_unprint = (req_data_byte < tsle_pkg::PRINT_LO) ||
                              (req_data_byte > tsle_pkg::PRINT_HI);
   assign q_item.last       = req_end_of_file;
   assign q_item.offset     = offset_wide[tsle_pkg::OFFSET_OUT_BITS-1:0];

   // The offset counts up per byte, wraps, and restarts after the last byte of a file.
   always_comb begin
      offset_in = offset_ff;
      if (q_push) begin
         if (req_end_of_file) begin
            offset_in = '0;
         end else begin
            offset_in = offset_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else begin
         offset_ff <= offset_in;
      end
   end

endmodule

// File: design/tsle_queue.sv
module tsle_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tsle_pkg::item_type push_item,
   output logic               push_ready,
   input  logic               pop,
   output logic               head_valid,
   output tsle_pkg::item_type head_item
);

   tsle_pkg::item_type                entry_ff [tsle_pkg::Q_DEPTH];
   logic [tsle_pkg::Q_PTR_BITS-1:0]   wr_ptr_ff;
   logic [tsle_pkg::Q_PTR_BITS-1:0]   rd_ptr_ff;
   logic [tsle_pkg::Q_PTR_BITS:0]     count_ff;
   logic [tsle_pkg::Q_PTR_BITS:0]     count_in;

   assign push_ready = (count_ff != (tsle_pkg::Q_PTR_BITS + 1)'(tsle_pkg::Q_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];

   // Occupancy follows pushes and pops; both may happen in one cycle.
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: design/tsle_back.sv
module tsle_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tsle_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [tsle_pkg::CSR_DATA_BITS-1:0]    csr_data,
   input  logic                                  q_valid,
   input  tsle_pkg::item_type                    q_item,
   output logic                                  q_pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [2:0]                            rsp_verdict,
   output logic [tsle_pkg::OFFSET_OUT_BITS-1:0]  rsp_error_offset,
   output logic                                  rsp_file_done
);

   // Configuration registers.
   logic       check_endings_ff;
   logic [2:0] expected_style_ff;
   logic       reject_zero_ff;
   logic       reject_unprint_ff;

   // Per-file state.
   tsle_pkg::pend_type pend_ff;
   tsle_pkg::pend_type pend_in;
   logic [2:0]         learned_ff;
   logic [2:0]         learned_in;
   logic               failed_ff;
   logic               failed_in;

   // Output register.
   logic                                 rsp_valid_ff;
   tsle_pkg::verdict_type                verdict_ff;
   tsle_pkg::verdict_type                verdict_in;
   logic [tsle_pkg::OFFSET_OUT_BITS-1:0] offset_ff;
   logic                                 done_ff;

   // Ending evaluation.
   tsle_pkg::pend_type next_wait;
   logic               found_valid;
   logic [2:0]         found_style;
   logic [2:0]         tail_style;
   logic               bad_end;
   logic               csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid;

   // Take the next queued byte when the output register is free or being drained.
   assign q_pop            = q_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_verdict      = verdict_ff;
   assign rsp_error_offset = offset_ff;
   assign rsp_file_done    = done_ff;

   // Settle a waiting break against the current byte and find the verdict.
   always_comb begin
      pend_in     = pend_ff;
      learned_in  = learned_ff;
      failed_in   = failed_ff;
      verdict_in  = tsle_pkg::VERDICT_OK;
      bad_end     = 1'b0;
      found_valid = 1'b0;
      found_style = tsle_pkg::STYLE_LEARN;
      tail_style  = tsle_pkg::STYLE_LEARN;
      next_wait   = q_item.is_cr ? tsle_pkg::WAIT_CR :
                    q_item.is_lf ? tsle_pkg::WAIT_LF : tsle_pkg::WAIT_NONE;

      if (failed_ff) begin
         verdict_in = tsle_pkg::VERDICT_FAILED;
      end else begin
         if (check_endings_ff) begin
            unique case (pend_ff)
               tsle_pkg::WAIT_CR: begin
                  found_valid = 1'b1;
                  if (q_item.is_lf) begin
                     found_style = tsle_pkg::STYLE_CRLF;
                     next_wait   = tsle_pkg::WAIT_NONE;
                  end else begin
                     found_style = tsle_pkg::STYLE_CR;
                  end
               end
               tsle_pkg::WAIT_LF: begin
                  found_valid = 1'b1;
                  if (q_item.is_cr) begin
                     found_style = tsle_pkg::STYLE_LFCR;
                     next_wait   = tsle_pkg::WAIT_NONE;
                  end else begin
                     found_style = tsle_pkg::STYLE_LF;
                  end
               end
               default: begin
                  found_valid = 1'b0;
               end
            endcase

            // Learn the first ending found, otherwise compare it with the style.
            if (found_valid) begin
               if (learned_in == tsle_pkg::STYLE_LEARN) begin
                  learned_in = found_style;
               end else begin
                  bad_end = (found_style != learned_in);
               end
            end
            pend_in = next_wait;

            // A break still waiting on the last byte ends as a single break.
            if (q_item.last && !bad_end && (next_wait != tsle_pkg::WAIT_NONE)) begin
               tail_style = (next_wait == tsle_pkg::WAIT_CR) ?
                            tsle_pkg::STYLE_CR : tsle_pkg::STYLE_LF;
               if (learned_in == tsle_pkg::STYLE_LEARN) begin
                  learned_in = tail_style;
               end else begin
                  bad_end = (tail_style != learned_in);
               end
               pend_in = tsle_pkg::WAIT_NONE;
            end
         end else begin
            pend_in = tsle_pkg::WAIT_NONE;
         end

         // Ending errors take priority over byte content errors.
         if (bad_end) begin
            verdict_in = tsle_pkg::VERDICT_ENDING;
         end else if (reject_zero_ff && q_item.is_zero) begin
            verdict_in = tsle_pkg::VERDICT_ZERO;
         end else if (reject_unprint_ff && q_item.is_unprint) begin
            verdict_in = tsle_pkg::VERDICT_UNPRINT;
         end
         failed_in = (verdict_in != tsle_pkg::VERDICT_OK);
      end

      // The last byte starts a fresh file.
      if (q_item.last) begin
         pend_in    = tsle_pkg::WAIT_NONE;
         learned_in = expected_style_ff;
         failed_in  = 1'b0;
      end
   end

   // Configuration writes and per-file state.
   always_ff @(posedge clock) begin
      if (reset) begin
         check_endings_ff  <= 1'b0;
         expected_style_ff <= tsle_pkg::STYLE_LEARN;
         reject_zero_ff    <= 1'b0;
         reject_unprint_ff <= 1'b0;
         pend_ff           <= tsle_pkg::WAIT_NONE;
         learned_ff        <= tsle_pkg::STYLE_LEARN;
         failed_ff         <= 1'b0;
      end else begin
         if (q_pop) begin
            pend_ff    <= pend_in;
            learned_ff <= learned_in;
            failed_ff  <= failed_in;
         end
         if (csr_write) begin
            unique case (csr_index)
               tsle_pkg::CSR_CHECK_ENDINGS: begin
                  check_endings_ff <= csr_data[0];
               end
               tsle_pkg::CSR_EXPECTED_STYLE: begin
                  expected_style_ff <= csr_data[2:0];
                  learned_ff        <= csr_data[2:0];
               end
               tsle_pkg::CSR_REJECT_ZERO: begin
                  reject_zero_ff <= csr_data[0];
               end
               tsle_pkg::CSR_REJECT_UNPRINTABLE: begin
                  reject_unprint_ff <= csr_data[0];
               end
               default: begin
                  check_endings_ff <= check_endings_ff;
               end
            endcase
         end
      end
   end

   // Output register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (q_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Output payload.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         verdict_ff <= verdict_in;
         offset_ff  <= q_item.offset;
         done_ff    <= q_item.last;
      end
   end

endmodule

// File: design/text_stream_line_ending_checker_unit.sv
// Checks a text file streamed one byte per beat: line endings must all follow one style
// (fixed by expected_style, or learned from the first ending when it is 0), and zero or
// unprintable bytes can be rejected. Every byte returns one verdict with its file offset;
// after the first error the rest of the file reports "already failed", and the last byte
// (end_of_file set) restarts all per-file state. A CR or LF is judged together with the
// byte after it, so a lone-break error lands on that following byte. The block takes one
// byte per clock cycle while its queue has room; a byte passes through the two-entry queue
// between the classifying front and the state-keeping back, and then into the output
// register, before its result is offered. With the output stalled the block holds three
// bytes before it stalls its input. Configuration writes are taken every cycle and must
// only be made while no byte is in flight.
module text_stream_line_ending_checker_unit #(
   parameter int OFFSET_BITS = tsle_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tsle_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [tsle_pkg::CSR_DATA_BITS-1:0]    csr_data,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [7:0]                            req_data_byte,
   input  logic                                  req_end_of_file,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [2:0]                            rsp_verdict,
   output logic [tsle_pkg::OFFSET_OUT_BITS-1:0]  rsp_error_offset,
   output logic                                  rsp_file_done
);

   logic               q_push;
   logic               q_ready;
   logic               q_pop;
   logic               q_valid;
   tsle_pkg::item_type push_item;
   tsle_pkg::item_type head_item;

   // Front: takes bytes, classifies them and counts offsets.
   tsle_front #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_end_of_file (req_end_of_file),
      .q_ready         (q_ready),
      .q_push          (q_push),
      .q_item          (push_item)
   );

   // Queue between the two halves.
   tsle_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (push_item),
      .push_ready (q_ready),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_item  (head_item)
   );

   // Back: line ending state, verdicts and configuration.
   tsle_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .q_valid          (q_valid),
      .q_item           (head_item),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_verdict      (rsp_verdict),
      .rsp_error_offset (rsp_error_offset),
      .rsp_file_done    (rsp_file_done)
   );

endmodule

// File: design/tsle_checker.sv
`include "text_stream_line_ending_checker_unit_assert.svh"

module tsle_checker #(
   parameter int OFFSET_BITS = tsle_pkg::OFFSET_BITS_DEFAULT
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [2:0]                            rsp_verdict,
   input logic [tsle_pkg::OFFSET_OUT_BITS-1:0]  rsp_error_offset,
   input logic                                  rsp_file_done
);

   localparam int WideBits = (OFFSET_BITS > tsle_pkg::OFFSET_OUT_BITS) ?
                             OFFSET_BITS : tsle_pkg::OFFSET_OUT_BITS;

   logic                                 rsp_beat;
   logic                                 failed_ff;
   logic [OFFSET_BITS-1:0]               count_ff;
   logic [WideBits-1:0]                  count_wide;
   logic [tsle_pkg::OFFSET_OUT_BITS-1:0] offset_expect;
   logic                                 verdict_error;
   logic                                 verdict_failed;
   logic                                 verdict_known;

   assign rsp_beat       = rsp_valid && rsp_ready;
   assign count_wide     = WideBits'(count_ff);
   assign offset_expect  = count_wide[tsle_pkg::OFFSET_OUT_BITS-1:0];
   assign verdict_error  = (rsp_verdict == tsle_pkg::VERDICT_ENDING) ||
                           (rsp_verdict == tsle_pkg::VERDICT_ZERO) ||
                           (rsp_verdict == tsle_pkg::VERDICT_UNPRINT);
   assign verdict_failed = (rsp_verdict == tsle_pkg::VERDICT_FAILED);
   assign verdict_known  = verdict_error || verdict_failed ||
                           (rsp_verdict == tsle_pkg::VERDICT_OK);

   // Track the expected offset and whether the file already failed, from result beats.
   always_ff @(posedge clock) begin
      if (reset) begin
         failed_ff <= 1'b0;
         count_ff  <= '0;
      end else if (rsp_beat) begin
         if (rsp_file_done) begin
            failed_ff <= 1'b0;
            count_ff  <= '0;
         end else begin
            failed_ff <= failed_ff || verdict_error;
            count_ff  <= count_ff + 1'b1;
         end
      end
   end

   // A stalled result stays put.
   `TSLE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_verdict))

   // Verdicts are always one of the defined codes.
   `TSLE_ASSERT_IMP(a_verdict_legal, rsp_valid, verdict_known)

   // Once a file has failed, every later byte of it reports the failure.
   `TSLE_ASSERT_IMP(a_sticky_fail, rsp_valid && failed_ff, verdict_failed)

   // No failure is reported before an error was seen in the file.
   `TSLE_ASSERT_IMP(a_no_early_fail, rsp_valid && !failed_ff, !verdict_failed)

   // Offsets count bytes in order and restart with each file.
   `TSLE_ASSERT_IMP(a_offset_order, rsp_valid, rsp_error_offset == offset_expect)

endmodule

bind text_stream_line_ending_checker_unit tsle_checker #(
   .OFFSET_BITS(OFFSET_BITS)
) u_tsle_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_verdict      (rsp_verdict),
   .rsp_error_offset (rsp_error_offset),
   .rsp_file_done    (rsp_file_done)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import tsle_pkg::*;

   // Style codes above LFCR match no ending at all.
   localparam logic [2:0] STYLE_UNKNOWN_LO = 3'd5;
   localparam logic [2:0] STYLE_UNKNOWN_HI = 3'd7;

   // Cycles without any accepted beat before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 2000;
   // Length of the long output stall that backs up the block.
   localparam int LONG_HOLD_CYCLES = 300;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_RANDOM,
      READY_PATTERN
   } ready_mode_type;

   typedef struct {
      verdict_type                verdict;
      logic [OFFSET_OUT_BITS-1:0] offset;
      logic                       done;
   } verdict_rec_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0]   csr_data;
   logic                       req_valid;
   logic                       req_ready;
   logic [7:0]                 req_data_byte;
   logic                       req_end_of_file;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [2:0]                 rsp_verdict;
   logic [OFFSET_OUT_BITS-1:0] rsp_error_offset;
   logic                       rsp_file_done;

   // Register copies and per-file state of the predictor.
   logic                       cfg_check   = 1'b0;
   logic [2:0]                 cfg_style   = STYLE_LEARN;
   logic                       cfg_zero    = 1'b0;
   logic                       cfg_unprint = 1'b0;
   pend_type                   pend_now    = WAIT_NONE;
   logic [2:0]                 style_now   = STYLE_LEARN;
   logic [OFFSET_OUT_BITS-1:0] offset_now  = '0;
   logic                       file_failed = 1'b0;

   verdict_rec_type verdicts_due[$];

   int mismatch_count  = 0;
   int results_checked = 0;
   int bytes_sent      = 0;
   int files_sent      = 0;
   int csr_writes      = 0;
   int idle_cycles     = 0;

   // Sender burst control.
   logic gaps_on    = 1'b1;
   int   burst_left = 0;

   // Receiver stall control.
   int             hold_request  = 0;
   int             hold_left     = 0;
   int             mode_left     = 0;
   ready_mode_type stall_mode    = READY_ALWAYS;
   logic [7:0]     stall_pattern = 8'hFF;

   text_stream_line_ending_checker_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_end_of_file  (req_end_of_file),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_verdict      (rsp_verdict),
      .rsp_error_offset (rsp_error_offset),
      .rsp_file_done    (rsp_file_done)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Compares a found ending with the enforced style; the first one is learned.
   function automatic logic style_clash(input logic [2:0] found);
      if (style_now == STYLE_LEARN) begin
         style_now = found;
         return 1'b0;
      end
      return found != style_now;
   endfunction

   // Pairs a waiting CR or LF with this byte and reports a bad ending.
   function automatic logic settle_breaks(input logic [7:0] b, input logic last);
      logic     bad;
      pend_type nxt;
      bad = 1'b0;
      if (b == BYTE_CR) begin
         nxt = WAIT_CR;
      end else if (b == BYTE_LF) begin
         nxt = WAIT_LF;
      end else begin
         nxt = WAIT_NONE;
      end
      if (pend_now == WAIT_CR) begin
         if (b == BYTE_LF) begin
            bad = style_clash(STYLE_CRLF);
            nxt = WAIT_NONE;
         end else begin
            bad = style_clash(STYLE_CR);
         end
      end else if (pend_now == WAIT_LF) begin
         if (b == BYTE_CR) begin
            bad = style_clash(STYLE_LFCR);
            nxt = WAIT_NONE;
         end else begin
            bad = style_clash(STYLE_LF);
         end
      end
      pend_now = nxt;
      // A break still waiting on the last byte counts as a single ending.
      if (last && !bad && pend_now != WAIT_NONE) begin
         bad = style_clash((pend_now == WAIT_CR) ? STYLE_CR : STYLE_LF);
         pend_now = WAIT_NONE;
      end
      return bad;
   endfunction

   // Works out the verdict of one byte and advances the per-file state.
   function automatic verdict_rec_type judge_byte(input logic [7:0] b, input logic last);
      verdict_rec_type r;
      logic            bad_end;
      r.verdict = VERDICT_OK;
      r.offset  = offset_now;
      r.done    = last;
      if (file_failed) begin
         r.verdict = VERDICT_FAILED;
      end else begin
         bad_end = 1'b0;
         if (cfg_check) begin
            bad_end = settle_breaks(b, last);
         end else begin
            pend_now = WAIT_NONE;
         end
         if (bad_end) begin
            r.verdict = VERDICT_ENDING;
         end else if (cfg_zero && b == BYTE_NUL) begin
            r.verdict = VERDICT_ZERO;
         end else if (cfg_unprint && (b < PRINT_LO || b > PRINT_HI)) begin
            r.verdict = VERDICT_UNPRINT;
         end
         if (r.verdict != VERDICT_OK) begin
            file_failed = 1'b1;
         end
      end
      if (last) begin
         pend_now    = WAIT_NONE;
         style_now   = cfg_style;
         offset_now  = '0;
         file_failed = 1'b0;
      end else begin
         offset_now = offset_now + 1'b1;
      end
      return r;
   endfunction

   task automatic flag_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("MISMATCH %s on result %0d: expected %0d, got %0d",
                     field, results_checked, want, got);
         end
      end
   endtask

   // Offers one byte, with a random gap first when the current burst is used up.
   task automatic send_byte(input logic [7:0] value, input logic last);
      @(negedge clock);
      if (gaps_on && burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end else if (burst_left > 0) begin
         burst_left--;
      end
      req_valid       = 1'b1;
      req_data_byte   = value;
      req_end_of_file = last;
      do @(posedge clock); while (req_ready !== 1'b1);
      verdicts_due.push_back(judge_byte(value, last));
      bytes_sent++;
      if (last) begin
         files_sent++;
      end
   endtask

   // Stops offering bytes and waits until every verdict has come back.
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (index)
         CSR_CHECK_ENDINGS: cfg_check = value[0];
         CSR_EXPECTED_STYLE: begin
            cfg_style = value[2:0];
            style_now = value[2:0];
         end
         CSR_REJECT_ZERO: cfg_zero = value[0];
         CSR_REJECT_UNPRINTABLE: cfg_unprint = value[0];
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Sends one file of mostly printable text with endings in the given style,
   // sprinkled with lone breaks, zero bytes and arbitrary bytes.
   task automatic send_text_file(input int len, input logic [2:0] style);
      logic [7:0] chunk [2];
      int         count;
      int         n;
      int         k;
      int         pick;
      n = 0;
      while (n < len) begin
         pick  = $urandom_range(0, 99);
         count = 1;
         if (pick < 65) begin
            chunk[0] = 8'($urandom_range(PRINT_LO, PRINT_HI));
         end else if (pick < 85) begin
            case (style)
               STYLE_CR: chunk[0] = BYTE_CR;
               STYLE_LF: chunk[0] = BYTE_LF;
               STYLE_CRLF: begin
                  chunk[0] = BYTE_CR;
                  chunk[1] = BYTE_LF;
                  count    = 2;
               end
               default: begin
                  chunk[0] = BYTE_LF;
                  chunk[1] = BYTE_CR;
                  count    = 2;
               end
            endcase
         end else if (pick < 90) begin
            chunk[0] = ($urandom_range(0, 1) != 0) ? BYTE_CR : BYTE_LF;
         end else if (pick < 94) begin
            chunk[0] = BYTE_NUL;
         end else begin
            chunk[0] = 8'($urandom_range(0, 255));
         end
         for (k = 0; k < count && n < len; k++) begin
            send_byte(chunk[k], n == len - 1);
            n++;
         end
      end
   endtask

   // With the reset settings nothing is rejected, not even breaks or zeros.
   task automatic test_default_config();
      send_byte(BYTE_NUL, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(BYTE_LF, 1'b1);
   endtask

   // Zero and unprintable rejection, their priority and the sticky failure.
   task automatic test_byte_rejects();
      write_csr(CSR_REJECT_ZERO, 8'd1);
      write_csr(CSR_REJECT_UNPRINTABLE, 8'd1);
      send_byte(PRINT_LO, 1'b0);
      send_byte(PRINT_HI, 1'b0);
      send_byte(PRINT_HI + 8'd1, 1'b0);
      send_byte("A", 1'b1);
      send_byte(BYTE_NUL, 1'b1);
      write_csr(CSR_REJECT_ZERO, 8'd0);
      send_byte(BYTE_NUL, 1'b1);
      write_csr(CSR_REJECT_UNPRINTABLE, 8'd0);
   endtask

   // Fixed styles: matching pairs, matching and mismatching singles, and a break
   // still waiting at the last byte.
   task automatic test_fixed_styles();
      write_csr(CSR_CHECK_ENDINGS, 8'd1);
      write_csr(CSR_EXPECTED_STYLE, 8'(STYLE_CR));
      send_byte(BYTE_CR, 1'b0);
      send_byte("a", 1'b0);
      send_byte(BYTE_LF, 1'b0);
      send_byte("b", 1'b1);
      write_csr(CSR_EXPECTED_STYLE, 8'(STYLE_LFCR));
      send_byte(BYTE_LF, 1'b0);
      send_byte(BYTE_CR, 1'b0);
      send_byte(BYTE_LF, 1'b1);
      write_csr(CSR_EXPECTED_STYLE, 8'(STYLE_CRLF));
      send_byte(BYTE_CR, 1'b0);
      send_byte(BYTE_LF, 1'b1);
   endtask

   // Learning from the first ending, then a style write in mid-file that
   // replaces the learned style.
   task automatic test_learn_and_reload();
      write_csr(CSR_EXPECTED_STYLE, 8'(STYLE_LEARN));
      send_byte("a", 1'b0);
      send_byte(BYTE_LF, 1'b0);
      send_byte("b", 1'b0);
      write_csr(CSR_EXPECTED_STYLE, 8'(STYLE_CR));
      send_byte(BYTE_CR, 1'b0);
      send_byte(BYTE_CR, 1'b1);
   endtask

   // Unknown styles reject every ending; an ending error wins over a zero byte.
   // Turning the check off drops a waiting break.
   task automatic test_unknown_style();
      write_csr(CSR_EXPECTED_STYLE, 8'(STYLE_UNKNOWN_HI));
      write_csr(CSR_REJECT_ZERO, 8'd1);
      send_byte(BYTE_LF, 1'b0);
      send_byte(BYTE_NUL, 1'b1);
      write_csr(CSR_EXPECTED_STYLE, 8'(STYLE_UNKNOWN_LO));
      send_byte(BYTE_LF, 1'b0);
      write_csr(CSR_CHECK_ENDINGS, 8'd0);
      send_byte("a", 1'b0);
      write_csr(CSR_CHECK_ENDINGS, 8'd1);
      send_byte("b", 1'b1);
      write_csr(CSR_REJECT_ZERO, 8'd0);
   endtask

   // Random files under a series of register settings, the extremes first.
   task automatic test_random_files();
      int         phase;
      int         quota;
      int         len;
      int         r;
      logic       chk;
      logic       zro;
      logic       unp;
      logic [2:0] sty;
      logic [2:0] file_style;
      for (phase = 0; phase < 9; phase++) begin
         if (phase == 0) begin
            chk = 1'b1;
            sty = STYLE_LFCR;
            zro = 1'b1;
            unp = 1'b1;
         end else if (phase == 1) begin
            chk = 1'b0;
            sty = STYLE_LEARN;
            zro = 1'b0;
            unp = 1'b0;
         end else begin
            r   = $urandom_range(0, 9);
            chk = ($urandom_range(0, 4) != 0);
            zro = ($urandom_range(0, 2) == 0);
            unp = ($urandom_range(0, 4) == 0);
            if (r < 3) begin
               sty = STYLE_LEARN;
            end else if (r < 9) begin
               sty = 3'($urandom_range(STYLE_CR, STYLE_LFCR));
            end else begin
               sty = 3'($urandom_range(STYLE_UNKNOWN_LO, STYLE_UNKNOWN_HI));
            end
         end
         write_csr(CSR_CHECK_ENDINGS, 8'(chk));
         write_csr(CSR_EXPECTED_STYLE, 8'(sty));
         write_csr(CSR_REJECT_ZERO, 8'(zro));
         write_csr(CSR_REJECT_UNPRINTABLE, 8'(unp));
         gaps_on = ($urandom_range(0, 3) != 0);
         quota   = bytes_sent + 40;
         while (bytes_sent < quota) begin
            len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 24);
            if (cfg_style >= STYLE_CR && cfg_style <= STYLE_LFCR
                && $urandom_range(0, 4) != 0) begin
               file_style = cfg_style;
            end else begin
               file_style = 3'($urandom_range(STYLE_CR, STYLE_LFCR));
            end
            send_text_file(len, file_style);
         end
      end
      gaps_on = 1'b1;
   endtask

   // The receiver holds off for a long stretch while bytes keep coming, so
   // the block fills up and stalls its input.
   task automatic test_backpressure();
      write_csr(CSR_CHECK_ENDINGS, 8'd1);
      write_csr(CSR_EXPECTED_STYLE, 8'(STYLE_LEARN));
      write_csr(CSR_REJECT_ZERO, 8'd0);
      write_csr(CSR_REJECT_UNPRINTABLE, 8'd0);
      gaps_on = 1'b0;
      @(posedge clock);
      hold_request = LONG_HOLD_CYCLES;
      send_text_file(40, STYLE_CRLF);
      send_text_file(20, STYLE_LF);
      gaps_on = 1'b1;
   endtask

   // Receiver: a long hold when asked, otherwise stall modes picked at random.
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready = 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode    = ready_mode_type'($urandom_range(READY_ALWAYS, READY_PATTERN));
            mode_left     = $urandom_range(20, 120);
            stall_pattern = 8'($urandom) | 8'h01;
         end
         mode_left--;
         case (stall_mode)
            READY_ALWAYS: rsp_ready = 1'b1;
            READY_RANDOM: rsp_ready = ($urandom_range(0, 3) != 0);
            default: begin
               stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
               rsp_ready     = stall_pattern[0];
            end
         endcase
      end
   end

   // Each result beat is checked against the oldest predicted verdict.
   always @(posedge clock) begin : check_results
      verdict_rec_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         results_checked++;
         if (verdicts_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("MISMATCH unexpected result: verdict %0d offset %0d done %0d",
                        rsp_verdict, rsp_error_offset, rsp_file_done);
            end
         end else begin
            want = verdicts_due.pop_front();
            flag_field("verdict", 32'(want.verdict), 32'(rsp_verdict));
            flag_field("error_offset", 32'(want.offset), 32'(rsp_error_offset));
            flag_field("file_done", 32'(want.done), 32'(rsp_file_done));
         end
      end
   end

   // Watchdog on beats of any channel.
   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_ready === 1'b1)
          || (rsp_valid === 1'b1 && rsp_ready === 1'b1)
          || (csr_valid === 1'b1 && csr_ready === 1'b1)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no beat for %0d cycles, %0d verdicts outstanding.",
                  idle_cycles, verdicts_due.size());
         $display("text_stream_line_ending_checker_unit verification failed");
         $finish;
      end
   end

   initial begin
      reset           = 1'b1;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      req_valid       = 1'b0;
      req_data_byte   = '0;
      req_end_of_file = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_default_config();
      test_byte_rejects();
      test_fixed_styles();
      test_learn_and_reload();
      test_unknown_style();
      test_random_files();
      test_backpressure();

      // Drain, then give stray results a chance to show up.
      wait_idle();
      repeat (8) @(posedge clock);

      $display("Checked %0d verdicts for %0d bytes in %0d files over %0d register writes.",
               results_checked, bytes_sent, files_sent, csr_writes);
      $display("Styles fixed, learned and unknown, byte rejection, sticky failure, %0s%0d",
               "a long output stall; mismatches seen: ", mismatch_count);
      if (mismatch_count == 0) begin
         $display("text_stream_line_ending_checker_unit verification clean");
      end else begin
         $display("text_stream_line_ending_checker_unit verification failed");
      end
      $finish;
   end

endmodule
